@@ rtl/core/adpcm_pkg.sv @@
`default_nettype none

package adpcm_pkg;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned PRED_W     = 4;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned PROD_W     = 2 * SAMPLE_W;
  // Scaled code reaches 2^29 and each product 2^30, so 35 bits never wrap.
  localparam int unsigned SUM_W      = 35;
  localparam int unsigned FRAC_BITS  = 11;
  localparam int unsigned BYTES_PER_FRAME = 9;

  localparam logic [SHIFT_W-1:0] BASE_SHIFT = SHIFT_W'(FRAC_BITS);

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DATA  = 2'd2;

  localparam logic [SAMPLE_W-1:0] SAT_MIN = 16'h8000;
  localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'h7FFF;

  typedef struct packed {
    logic take;  // input item accepted this cycle
    logic mul;   // register the two predictor products
    logic acc0;  // finish the first sample of the byte
    logic acc1;  // finish the second sample of the byte
  } ctrl_cmd_t;

  typedef struct packed {
    logic decode_item;  // offered item is a data byte that carries samples
    logic out_free;     // output register can take a result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/adpcm_in_if.sv @@
`default_nettype none

interface adpcm_in_if import adpcm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic [PRED_W-1:0]          predictor_index;
  logic signed [SAMPLE_W-1:0] coef_older;
  logic signed [SAMPLE_W-1:0] coef_newer;
  logic                       clear_history;
  logic signed [SAMPLE_W-1:0] history_older;
  logic signed [SAMPLE_W-1:0] history_newer;
  logic [BYTE_W-1:0]          data_byte;
  logic                       final_frame;

  modport source (
    output valid, req_type, predictor_index, coef_older, coef_newer,
           clear_history, history_older, history_newer, data_byte, final_frame,
    input  ready
  );
  modport sink (
    input  valid, req_type, predictor_index, coef_older, coef_newer,
           clear_history, history_older, history_newer, data_byte, final_frame,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/adpcm_out_if.sv @@
`default_nettype none

interface adpcm_out_if import adpcm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic                       frame_done;
  logic                       run_done;

  modport source (
    output valid, sample, last, frame_done, run_done,
    input  ready
  );
  modport sink (
    input  valid, sample, last, frame_done, run_done,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/adpcm_two_tap_frame_decoder_unit.sv @@
`default_nettype none

// Channel   Dir   Modport  Content
// in_i      in    sink     load, start or data byte item
// out_o     out   source   two decoded 16-bit samples per data byte
//
// A data byte that carries samples runs through these steps: the accept cycle also
// registers the two predictor products, then one accumulate step, one product
// step and one accumulate step. The two dependent multiply-accumulate passes
// share the one pair of 16x16 multipliers, so they run one after the other.
// Load, start and header items are taken in the idle state and start no steps.
// Reset is asynchronous and active low; it clears the coefficient table,
// history and frame state.
// A full output register stalls the accumulate steps; a new item is taken
// while the second sample of the previous byte still waits in that register.

module adpcm_two_tap_frame_decoder_unit import adpcm_pkg::*; #(
  parameter int unsigned NUM_PREDICTORS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  adpcm_in_if.sink    in_i,
  adpcm_out_if.source out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller only sequences the steps of one item; all state that
  // the stream defines (coefficients, history, frame position) lives in the
  // datapath.
  adpcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  adpcm_dp #(
    .NUM_PREDICTORS (NUM_PREDICTORS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .req_type_i        (in_i.req_type),
    .predictor_index_i (in_i.predictor_index),
    .coef_older_i      (in_i.coef_older),
    .coef_newer_i      (in_i.coef_newer),
    .clear_history_i   (in_i.clear_history),
    .history_older_i   (in_i.history_older),
    .history_newer_i   (in_i.history_newer),
    .data_byte_i       (in_i.data_byte),
    .final_frame_i     (in_i.final_frame),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .sample_o          (out_o.sample),
    .last_o            (out_o.last),
    .frame_done_o      (out_o.frame_done),
    .run_done_o        (out_o.run_done)
  );

endmodule

`default_nettype wire

@@ rtl/core/adpcm_ctrl.sv @@
`default_nettype none

module adpcm_ctrl import adpcm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC0 = 2'd1;
  localparam logic [1:0] S_MUL1 = 2'd2;
  localparam logic [1:0] S_ACC1 = 2'd3;

  logic [1:0] state_q, state_d;
  logic       take;

  assign in_ready_o = (state_q == S_IDLE);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.take = take;
    cmd_o.mul  = (state_q == S_IDLE) || (state_q == S_MUL1);
    cmd_o.acc0 = (state_q == S_ACC0) && status_i.out_free;
    cmd_o.acc1 = (state_q == S_ACC1) && status_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take && status_i.decode_item) state_d = S_ACC0;
      end
      S_ACC0: begin
        if (status_i.out_free) state_d = S_MUL1;
      end
      S_MUL1: state_d = S_ACC1;
      S_ACC1: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_decode_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && status_i.decode_item) |=> (state_q == S_ACC0))
    else $error("decode byte did not enter first accumulate step");

  a_mul_then_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL1) |=> (state_q == S_ACC1))
    else $error("second product step not followed by accumulate");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ACC0) && !status_i.out_free) |=> (state_q == S_ACC0))
    else $error("first sample left accumulate while output was full");

endmodule

`default_nettype wire

@@ rtl/core/adpcm_dp.sv @@
`default_nettype none

module adpcm_dp import adpcm_pkg::*; #(
  parameter int unsigned NUM_PREDICTORS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ctrl_cmd_t                  cmd_i,
  output dp_status_t                      status_o,
  input  wire logic [REQ_W-1:0]           req_type_i,
  input  wire logic [PRED_W-1:0]          predictor_index_i,
  input  wire logic signed [SAMPLE_W-1:0] coef_older_i,
  input  wire logic signed [SAMPLE_W-1:0] coef_newer_i,
  input  wire logic                       clear_history_i,
  input  wire logic signed [SAMPLE_W-1:0] history_older_i,
  input  wire logic signed [SAMPLE_W-1:0] history_newer_i,
  input  wire logic [BYTE_W-1:0]          data_byte_i,
  input  wire logic                       final_frame_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic signed [SAMPLE_W-1:0]      sample_o,
  output logic                            last_o,
  output logic                            frame_done_o,
  output logic                            run_done_o
);

  localparam int unsigned IDX_W = (NUM_PREDICTORS > 1) ? $clog2(NUM_PREDICTORS) : 1;

  logic signed [SAMPLE_W-1:0] coef_old_q [NUM_PREDICTORS];
  logic signed [SAMPLE_W-1:0] coef_new_q [NUM_PREDICTORS];

  logic signed [SAMPLE_W-1:0] hist_older_q, hist_newer_q;
  logic [SHIFT_W-1:0]         frame_shift_q;
  logic [PRED_W-1:0]          frame_pred_q;
  logic [POS_W-1:0]           byte_pos_q;
  logic [BYTE_W-1:0]          byte_q;
  logic                       fdone_q, fin_q;
  logic signed [PROD_W-1:0]   p_older_q, p_newer_q;

  logic                       out_valid_q, out_last_q, out_fdone_q, out_rdone_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;

  logic signed [SAMPLE_W-1:0] co_sel, cn_sel;
  logic                       load_ok, pred_ok, is_data, is_header, pos_end;
  logic signed [NIB_W-1:0]    code;
  logic signed [SUM_W-1:0]    code_ext, sum, quot;
  logic signed [SAMPLE_W-1:0] sat;
  logic                       out_free;

  assign is_data   = cmd_i.take && (req_type_i == REQ_DATA);
  assign is_header = is_data && (byte_pos_q == '0);
  assign load_ok   = {1'b0, predictor_index_i} < (PRED_W + 1)'(NUM_PREDICTORS);
  assign pred_ok   = {1'b0, frame_pred_q} < (PRED_W + 1)'(NUM_PREDICTORS);
  assign pos_end   = (byte_pos_q == POS_W'(BYTES_PER_FRAME - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  assign status_o.decode_item = (req_type_i == REQ_DATA) && (byte_pos_q != '0);
  assign status_o.out_free    = out_free;

  // A header naming an absent pair decodes with both coefficients zero.
  always_comb begin
    co_sel = '0;
    cn_sel = '0;
    if (pred_ok) begin
      co_sel = coef_old_q[frame_pred_q[IDX_W-1:0]];
      cn_sel = coef_new_q[frame_pred_q[IDX_W-1:0]];
    end
  end

  always_comb begin
    code     = cmd_i.acc1 ? $signed(byte_q[NIB_W-1:0]) : $signed(byte_q[BYTE_W-1:NIB_W]);
    code_ext = SUM_W'(code);
    sum      = (code_ext <<< frame_shift_q) + SUM_W'(p_older_q) + SUM_W'(p_newer_q);
    quot     = sum >>> FRAC_BITS;
    if (quot[SUM_W-1:SAMPLE_W-1] == {(SUM_W - SAMPLE_W + 1){quot[SAMPLE_W-1]}}) begin
      sat = quot[SAMPLE_W-1:0];
    end else begin
      sat = quot[SUM_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PREDICTORS; i++) begin
        coef_old_q[i] <= '0;
        coef_new_q[i] <= '0;
      end
    end else if (cmd_i.take && (req_type_i == REQ_LOAD) && load_ok) begin
      coef_old_q[predictor_index_i[IDX_W-1:0]] <= coef_older_i;
      coef_new_q[predictor_index_i[IDX_W-1:0]] <= coef_newer_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_older_q  <= '0;
      hist_newer_q  <= '0;
      frame_shift_q <= BASE_SHIFT;
      frame_pred_q  <= '0;
      byte_pos_q    <= '0;
    end else begin
      if (cmd_i.take && (req_type_i == REQ_START)) begin
        hist_older_q <= clear_history_i ? '0 : history_older_i;
        hist_newer_q <= clear_history_i ? '0 : history_newer_i;
        byte_pos_q   <= '0;
      end else if (is_header) begin
        frame_shift_q <= BASE_SHIFT + SHIFT_W'(data_byte_i[BYTE_W-1:NIB_W]);
        frame_pred_q  <= data_byte_i[NIB_W-1:0];
        byte_pos_q    <= POS_W'(1);
      end else if (is_data) begin
        byte_pos_q <= pos_end ? '0 : byte_pos_q + POS_W'(1);
      end else if (cmd_i.acc0 || cmd_i.acc1) begin
        hist_older_q <= hist_newer_q;
        hist_newer_q <= sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_data) begin
      byte_q  <= data_byte_i;
      fdone_q <= pos_end;
      fin_q   <= final_frame_i;
    end
    if (cmd_i.mul) begin
      p_older_q <= hist_older_q * co_sel;
      p_newer_q <= hist_newer_q * cn_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.acc0 || cmd_i.acc1) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc0 || cmd_i.acc1) begin
      out_sample_q <= sat;
      out_last_q   <= cmd_i.acc1;
      out_fdone_q  <= cmd_i.acc1 && fdone_q;
      out_rdone_q  <= cmd_i.acc1 && fdone_q && fin_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_o     = out_sample_q;
  assign last_o       = out_last_q;
  assign frame_done_o = out_fdone_q;
  assign run_done_o   = out_rdone_q;

  a_first_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc0 |=> (out_valid_q && !out_last_q && !out_fdone_q && !out_rdone_q))
    else $error("first sample of a byte not presented correctly");

  a_second_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc1 |=> (out_valid_q && out_last_q))
    else $error("second sample of a byte not marked last");

  a_history_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.acc0 || cmd_i.acc1) |=> (hist_older_q == $past(hist_newer_q)))
    else $error("history did not advance with a decoded sample");

endmodule

`default_nettype wire

@@ verif/tb_adpcm_two_tap_frame_decoder_unit.sv @@
`timescale 1ns / 100ps

module tb_adpcm_two_tap_frame_decoder_unit;
  import adpcm_pkg::*;

  // The block is built with its default table size, and the local predictor uses the same.
  localparam int unsigned NUM_PRED     = 16;
  // Request code 3 is undefined, and the block must drop it without a result.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  // Watchdog limit in clock cycles. A correct run with the heaviest pacing stays far below it.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Quiet cycles after the last sample so that a late, stray output is still caught.
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned ITEMS_PER_PHASE = 175;

  // Handshake pacing for each phase of the random stimulus.
  typedef enum int unsigned {
    PACE_FREE,
    PACE_SRC_IDLE,
    PACE_SNK_STALL,
    PACE_BOTH
  } pace_e;

  // One input item exactly as it goes onto the input channel.
  typedef struct {
    logic [REQ_W-1:0]           req;
    logic [PRED_W-1:0]          idx;
    logic signed [SAMPLE_W-1:0] c_old;
    logic signed [SAMPLE_W-1:0] c_new;
    logic                       clr;
    logic signed [SAMPLE_W-1:0] h_old;
    logic signed [SAMPLE_W-1:0] h_new;
    logic [BYTE_W-1:0]          byte_v;
    logic                       fin;
  } dec_req_t;

  // One decoded sample with its framing flags.
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       frame_done;
    logic                       run_done;
  } dec_sample_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  adpcm_in_if  in_bus ();
  adpcm_out_if out_bus ();

  adpcm_two_tap_frame_decoder_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  dec_req_t    req_fifo[$];     // items waiting to be driven
  dec_sample_t sample_fifo[$];  // decoded samples the block still owes
  dec_req_t    cur_req;         // item currently on the input channel
  dec_sample_t exp_s;
  logic        in_fire = 1'b0;  // input handshake seen at the last rising edge
  pace_e       pace = PACE_FREE;

  int unsigned cycle_cnt    = 0;
  int unsigned err_cnt      = 0;
  int unsigned items_taken  = 0;
  int unsigned samples_seen = 0;

  // The local copy of the decoder state. It is updated only by accepted items.
  logic signed [SAMPLE_W-1:0] tbl_older [NUM_PRED];
  logic signed [SAMPLE_W-1:0] tbl_newer [NUM_PRED];
  logic signed [SAMPLE_W-1:0] prev_older;
  logic signed [SAMPLE_W-1:0] prev_newer;
  logic [SHIFT_W-1:0]         cur_shift;
  logic [PRED_W-1:0]          cur_pred;
  logic [POS_W-1:0]           byte_pos;

  // This decodes one 4-bit code and advances the two-sample history.
  // The sum is formed in 64 bits, so it cannot wrap. The arithmetic right shift
  // rounds toward minus infinity, as the block does.
  function automatic logic signed [SAMPLE_W-1:0] decode_nibble(input logic [NIB_W-1:0] nib);
    longint code;
    longint co;
    longint cn;
    longint acc;
    longint q;
    code = longint'($signed(nib));
    co   = 0;
    cn   = 0;
    // A header that selects a pair outside the table decodes with zero coefficients.
    if (int'(cur_pred) < NUM_PRED) begin
      co = longint'(tbl_older[cur_pred]);
      cn = longint'(tbl_newer[cur_pred]);
    end
    acc = (code <<< cur_shift) + longint'(prev_older) * co + longint'(prev_newer) * cn;
    q   = acc >>> FRAC_BITS;
    if (q < longint'($signed(SAT_MIN))) q = longint'($signed(SAT_MIN));
    if (q > longint'($signed(SAT_MAX))) q = longint'($signed(SAT_MAX));
    prev_older = prev_newer;
    prev_newer = q[SAMPLE_W-1:0];
    return q[SAMPLE_W-1:0];
  endfunction

  // This applies one accepted item to the local state and queues the samples it must give.
  function automatic void predict_samples(input dec_req_t r);
    logic signed [SAMPLE_W-1:0] s0;
    logic signed [SAMPLE_W-1:0] s1;
    logic                       fdone;
    case (r.req)
      REQ_LOAD: begin
        if (int'(r.idx) < NUM_PRED) begin
          tbl_older[r.idx] = r.c_old;
          tbl_newer[r.idx] = r.c_new;
        end
      end
      REQ_START: begin
        prev_older = r.clr ? '0 : r.h_old;
        prev_newer = r.clr ? '0 : r.h_new;
        // A start item always sends the decoder back to expecting a header,
        // even in the middle of a frame.
        byte_pos   = '0;
      end
      REQ_DATA: begin
        if (byte_pos == '0) begin
          // A header byte sets the shift and the predictor but gives no samples.
          cur_shift = BASE_SHIFT + SHIFT_W'(r.byte_v[7:4]);
          cur_pred  = r.byte_v[3:0];
          byte_pos  = POS_W'(1);
        end else begin
          s0    = decode_nibble(r.byte_v[7:4]);
          s1    = decode_nibble(r.byte_v[3:0]);
          fdone = (byte_pos == POS_W'(BYTES_PER_FRAME - 1));
          byte_pos = fdone ? '0 : byte_pos + 1'b1;
          sample_fifo.push_back('{sample: s0, last: 1'b0, frame_done: 1'b0, run_done: 1'b0});
          sample_fifo.push_back('{sample: s1, last: 1'b1, frame_done: fdone,
                                  run_done: fdone && r.fin});
        end
      end
      default: ;  // The undefined request code is dropped.
    endcase
  endfunction

  function automatic void report_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      err_cnt++;
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
    end
  endfunction

  function automatic bit src_idles();
    return (pace == PACE_SRC_IDLE && $urandom_range(99) < 72) ||
           (pace == PACE_BOTH && $urandom_range(99) < 11);
  endfunction

  function automatic bit snk_stalls();
    return (pace == PACE_SNK_STALL && $urandom_range(99) < 72) ||
           (pace == PACE_BOTH && $urandom_range(99) < 11);
  endfunction

  // This returns an item of the given kind. Every field is random, so the fields
  // that this kind does not use still toggle on the bus.
  function automatic dec_req_t rand_req(input logic [REQ_W-1:0] kind);
    dec_req_t r;
    r.req    = kind;
    r.idx    = PRED_W'($urandom);
    r.c_old  = SAMPLE_W'($urandom);
    r.c_new  = SAMPLE_W'($urandom);
    r.clr    = 1'($urandom);
    r.h_old  = SAMPLE_W'($urandom);
    r.h_new  = SAMPLE_W'($urandom);
    r.byte_v = BYTE_W'($urandom);
    r.fin    = 1'($urandom);
    return r;
  endfunction

  // Half of the coefficients cover the full range, so saturation comes often.
  // The other half are small values of the kind a real codebook has.
  function automatic logic signed [SAMPLE_W-1:0] rand_coef();
    int v;
    v = int'($urandom_range(8191)) - 4096;
    return $urandom_range(1) ? SAMPLE_W'($urandom) : SAMPLE_W'(v);
  endfunction

  task automatic push_load(input logic [PRED_W-1:0] idx, input logic signed [15:0] co,
                           input logic signed [15:0] cn);
    dec_req_t r;
    r       = rand_req(REQ_LOAD);
    r.idx   = idx;
    r.c_old = co;
    r.c_new = cn;
    req_fifo.push_back(r);
  endtask

  task automatic push_start(input logic clr, input logic signed [15:0] ho,
                            input logic signed [15:0] hn);
    dec_req_t r;
    r       = rand_req(REQ_START);
    r.clr   = clr;
    r.h_old = ho;
    r.h_new = hn;
    req_fifo.push_back(r);
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fin);
    dec_req_t r;
    r        = rand_req(REQ_DATA);
    r.byte_v = b;
    r.fin    = fin;
    req_fifo.push_back(r);
  endtask

  // Most of the random stream is well formed: a start item followed by one to three
  // complete frames, and the last of them is usually marked final. The rest is noise
  // at a low rate: loads between runs, undefined requests, and start or load items
  // that break into a frame.
  task automatic add_random_stream(input int unsigned n_items);
    int unsigned made;
    int unsigned frames;
    int unsigned pick;
    bit          fin;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        push_load(PRED_W'($urandom), rand_coef(), rand_coef());
        made++;
      end else if (pick < 12) begin
        // The block drops these items, so they do not count toward the total.
        req_fifo.push_back(rand_req(REQ_UNUSED));
      end else begin
        push_start(1'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        made++;
        frames = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++) begin
          fin = (f == frames - 1) && ($urandom_range(3) != 0);
          for (int b = 0; b < BYTES_PER_FRAME; b++) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
              push_start(1'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
              made++;
            end else if (pick < 4) begin
              push_load(PRED_W'($urandom), rand_coef(), rand_coef());
              made++;
            end
            // Now and then the final flag is flipped on a single byte.
            push_byte(BYTE_W'($urandom), fin ^ (pick >= 96));
            made++;
          end
        end
      end
    end
  endtask

  // This waits until every queued item has been accepted and every expected sample has come.
  task automatic wait_drained();
    while (req_fifo.size() != 0 || in_bus.valid || sample_fifo.size() != 0)
      @(posedge clk_i);
  endtask

  // Monitor and checker. Outputs are sampled at the rising edge. A sample is checked
  // before the input item accepted at the same edge updates the local state. This
  // order is safe because the block registers its output, so no item can give a
  // sample at the edge where it is accepted.
  always @(posedge clk_i) begin
    in_fire   <= in_bus.valid && in_bus.ready;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        samples_seen++;
        if (sample_fifo.size() == 0) begin
          err_cnt++;
          $error("sample %0d arrived with no sample expected", out_bus.sample);
        end else begin
          exp_s = sample_fifo.pop_front();
          report_field("sample", int'(exp_s.sample), int'(out_bus.sample));
          report_field("last", int'(exp_s.last), int'(out_bus.last));
          report_field("frame_done", int'(exp_s.frame_done), int'(out_bus.frame_done));
          report_field("run_done", int'(exp_s.run_done), int'(out_bus.run_done));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        items_taken++;
        predict_samples(cur_req);
      end
    end
  end

  // Driver. Inputs change at the falling edge. A new item goes out only when the
  // channel is empty or the item on it was taken at the last rising edge. In every
  // cycle the driver either keeps valid high or sets it once, and never sets it twice.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_bus.valid || in_fire) begin
        if (req_fifo.size() != 0 && !src_idles()) begin
          cur_req = req_fifo.pop_front();
          in_bus.req_type        <= cur_req.req;
          in_bus.predictor_index <= cur_req.idx;
          in_bus.coef_older      <= cur_req.c_old;
          in_bus.coef_newer      <= cur_req.c_new;
          in_bus.clear_history   <= cur_req.clr;
          in_bus.history_older   <= cur_req.h_old;
          in_bus.history_newer   <= cur_req.h_new;
          in_bus.data_byte       <= cur_req.byte_v;
          in_bus.final_frame     <= cur_req.fin;
          in_bus.valid           <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= !snk_stalls();
    end
  end

  // Watchdog. If the run does not end by itself before the limit, it fails.
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Stimulus sequence and end of the run.
  initial begin
    // All block inputs have known values from time zero.
    in_bus.valid           = 1'b0;
    in_bus.req_type        = REQ_LOAD;
    in_bus.predictor_index = '0;
    in_bus.coef_older      = '0;
    in_bus.coef_newer      = '0;
    in_bus.clear_history   = 1'b0;
    in_bus.history_older   = '0;
    in_bus.history_newer   = '0;
    in_bus.data_byte       = '0;
    in_bus.final_frame     = 1'b0;
    out_bus.ready          = 1'b0;

    // The local state starts at its reset values.
    for (int i = 0; i < NUM_PRED; i++) begin
      tbl_older[i] = '0;
      tbl_newer[i] = '0;
    end
    prev_older = '0;
    prev_newer = '0;
    cur_shift  = BASE_SHIFT;
    cur_pred   = '0;
    byte_pos   = '0;

    // Reset is released at a falling edge, away from the edges where the block samples.
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Extreme coefficients go into the first and the last slot, and
    // one undefined request is sent. A frame with the largest shift follows, with
    // extreme codes. A start item that loads extreme history then breaks into that
    // frame. The frame after it uses the last slot and is marked final. A load into
    // that slot in the middle of that frame changes the coefficients for the rest of it
    // but not the framing. Decoding then goes on after the final frame.
    push_load(4'd0, 16'sh8000, 16'sh7FFF);
    push_load(4'd15, 16'sh7FFF, 16'sh8000);
    req_fifo.push_back(rand_req(REQ_UNUSED));
    push_start(1'b1, 16'sh1234, -16'sh1234);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h78, 1'b0);
    push_byte(8'h87, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_start(1'b0, 16'sh8000, 16'sh7FFF);
    push_byte(8'h0F, 1'b1);
    push_byte(8'h80, 1'b1);
    push_byte(8'h7F, 1'b1);
    push_load(4'd15, 16'sh0400, -16'sh0200);
    for (int i = 0; i < 6; i++) push_byte(8'h1E, 1'b1);
    push_byte(8'h31, 1'b0);
    push_byte(8'hFF, 1'b0);

    // Random part. Each phase has its own handshake pacing. The first phase has no
    // idling at all.
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      pace = pace_e'(p);
      add_random_stream(ITEMS_PER_PHASE);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sample_fifo.size() != 0) begin
      err_cnt++;
      $error("%0d expected samples never arrived", sample_fifo.size());
    end

    $display("Decoded %0d samples from %0d accepted items (loads, starts, headers, data).",
             samples_seen, items_taken);
    $display("Pacing covered free flow, idle source, stalled sink and mixed gaps.");
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
